/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion helpers used by tksd_core.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Property must never hold at a clock edge outside reset.
`define ASSERT_NEVER(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) \
        else $error(msg);

`endif

/* hdl/tksd_pkg.sv */
// ----------------------------------------------------------------------------
// tksd_pkg
// Types, constants and lookup tables of the terminal key sequence decoder.
// ----------------------------------------------------------------------------
package tksd_pkg;

    localparam int MAX_SEQ_LEN = 7;
    localparam int SEQ_DEPTH   = MAX_SEQ_LEN - 1;
    localparam int LEN_W       = $clog2(MAX_SEQ_LEN + 1);
    localparam int IDX_W       = $clog2(SEQ_DEPTH);
    localparam int CAND_W      = 8 * SEQ_DEPTH;
    localparam int TEXT_W      = 40;
    localparam int CMP_W       = (CAND_W > TEXT_W) ? CAND_W : TEXT_W;
    localparam int TICK_W      = 16;
    localparam int SEQ_COUNT   = 33;

    localparam logic [1:0] KIND_BYTE = 2'd0;
    localparam logic [1:0] KIND_TICK = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;

    localparam logic [5:0] KEY_CHAR = 6'd0;
    localparam logic [5:0] KEY_ESC  = 6'd1;
    localparam logic [5:0] KEY_NONE = 6'd0;

    localparam logic [7:0] BYTE_ESC   = 8'h1B;
    localparam logic [7:0] BYTE_CSI   = 8'h5B;
    localparam logic [7:0] BYTE_SS3   = 8'h4F;
    localparam logic [7:0] BYTE_SPACE = 8'h20;
    localparam logic [7:0] BYTE_TILDE = 8'h7E;
    localparam logic [7:0] BYTE_ZERO  = 8'h00;

    localparam logic [TICK_W-1:0] TIMEOUT_RESET = 16'd200;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_ESC,
        MODE_SEQ
    } mode_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] byte_value;
    } item_t;

    typedef struct packed {
        logic  vld;
        item_t item;
    } in_stage_t;

    typedef struct packed {
        logic [5:0]        code;
        logic [2:0]        len;
        logic [TEXT_W-1:0] text;
    } seq_entry_t;

    // Text is right-justified: first byte after ESC in the highest used byte.
    localparam seq_entry_t SEQ_TABLE [SEQ_COUNT] = '{
        '{6'd7,  3'd3, TEXT_W'("[1~")},   '{6'd16, 3'd3, TEXT_W'("[2~")},
        '{6'd17, 3'd3, TEXT_W'("[3~")},   '{6'd10, 3'd3, TEXT_W'("[4~")},
        '{6'd18, 3'd3, TEXT_W'("[5~")},   '{6'd19, 3'd3, TEXT_W'("[6~")},
        '{6'd7,  3'd3, TEXT_W'("[7~")},   '{6'd10, 3'd3, TEXT_W'("[8~")},
        '{6'd20, 3'd5, TEXT_W'("[1;5D")}, '{6'd21, 3'd5, TEXT_W'("[1;5C")},
        '{6'd14, 3'd2, TEXT_W'("[A")},    '{6'd13, 3'd2, TEXT_W'("[B")},
        '{6'd11, 3'd2, TEXT_W'("[C")},    '{6'd8,  3'd2, TEXT_W'("[D")},
        '{6'd10, 3'd2, TEXT_W'("[F")},    '{6'd7,  3'd2, TEXT_W'("[H")},
        '{6'd22, 3'd3, TEXT_W'("[[A")},   '{6'd23, 3'd3, TEXT_W'("[[B")},
        '{6'd24, 3'd3, TEXT_W'("[[C")},   '{6'd25, 3'd3, TEXT_W'("[[D")},
        '{6'd26, 3'd3, TEXT_W'("[[E")},
        '{6'd22, 3'd2, TEXT_W'("OP")},    '{6'd23, 3'd2, TEXT_W'("OQ")},
        '{6'd24, 3'd2, TEXT_W'("OR")},    '{6'd25, 3'd2, TEXT_W'("OS")},
        '{6'd26, 3'd4, TEXT_W'("[15~")},  '{6'd27, 3'd4, TEXT_W'("[17~")},
        '{6'd28, 3'd4, TEXT_W'("[18~")},  '{6'd29, 3'd4, TEXT_W'("[19~")},
        '{6'd30, 3'd4, TEXT_W'("[20~")},  '{6'd31, 3'd4, TEXT_W'("[21~")},
        '{6'd32, 3'd4, TEXT_W'("[23~")},  '{6'd33, 3'd4, TEXT_W'("[24~")}
    };

    function automatic logic [5:0] control_key(input logic [7:0] b);
        logic [5:0] k;
        unique case (b)
            8'h08:   k = 6'd2;
            8'h0D:   k = 6'd3;
            8'h0A:   k = 6'd4;
            8'h09:   k = 6'd5;
            8'h00:   k = 6'd6;
            8'h01:   k = 6'd7;
            8'h02:   k = 6'd8;
            8'h03:   k = 6'd9;
            8'h04:   k = 6'd10;
            8'h05:   k = 6'd10;
            8'h06:   k = 6'd11;
            8'h0B:   k = 6'd12;
            8'h0E:   k = 6'd13;
            8'h10:   k = 6'd14;
            8'h15:   k = 6'd15;
            8'h7F:   k = 6'd2;
            default: k = KEY_NONE;
        endcase
        return k;
    endfunction

    // First exact match wins; KEY_NONE on a miss.
    function automatic logic [5:0] seq_lookup(input logic [CAND_W-1:0] cand,
                                              input logic [LEN_W-1:0]  n);
        logic [5:0] code;
        code = KEY_NONE;
        for (int i = SEQ_COUNT - 1; i >= 0; i--) begin
            if ((LEN_W'(SEQ_TABLE[i].len) == n) &&
                (CMP_W'(SEQ_TABLE[i].text) == CMP_W'(cand)))
            begin
                code = SEQ_TABLE[i].code;
            end
        end
        return code;
    endfunction

endpackage

/* hdl/tksd_in_stage.sv */
// ----------------------------------------------------------------------------
// tksd_in_stage
// Input register: holds one event word until the decoder takes it.
// ----------------------------------------------------------------------------
module tksd_in_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         kind,
    input  logic [7:0]         byte_value,
    input  logic               take,
    output tksd_pkg::in_stage_t stage
);
    import tksd_pkg::*;

    logic  vld_reg;
    logic  vld_next;
    item_t item_reg;

    assign in_ready = !vld_reg || take;

    always_comb
    begin
        vld_next = vld_reg;
        if (in_valid && in_ready)
        begin
            vld_next = 1'b1;
        end
        else if (take)
        begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= '{kind: kind, byte_value: byte_value};
        end
    end

    assign stage = '{vld: vld_reg, item: item_reg};

endmodule

/* hdl/tksd_core.sv */
// ----------------------------------------------------------------------------
// tksd_core
// Parser state, sequence match and result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tksd_core (
    input  logic                clk,
    input  logic                rst_n,
    input  tksd_pkg::in_stage_t stage,
    output logic                take,
    input  logic                cfg_we,
    input  logic [15:0]         cfg_data,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                status,
    output logic [5:0]          key_code,
    output logic [7:0]          char_value
);
    import tksd_pkg::*;

    mode_t             mode_reg, mode_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [TICK_W-1:0] tick_reg, tick_next;
    logic [TICK_W-1:0] timeout_reg;
    logic [7:0]        seq_reg  [SEQ_DEPTH];
    logic [7:0]        seq_next [SEQ_DEPTH];
    logic              out_vld_reg, out_vld_next;
    logic              status_reg, status_next;
    logic [5:0]        key_reg, key_next;
    logic [7:0]        char_reg, char_next;

    logic              res_vld;
    logic [TICK_W-1:0] tick_inc;
    logic [IDX_W-1:0]  wr_idx;
    logic [LEN_W-1:0]  match_len;
    logic [CAND_W-1:0] cand;
    logic [5:0]        ctl_key;
    logic [5:0]        seq_key;
    logic [7:0]        b;

    assign take     = stage.vld && (!out_vld_reg || out_ready);
    assign b        = stage.item.byte_value;
    assign tick_inc = (tick_reg == '1) ? tick_reg : tick_reg + 1'b1;
    assign ctl_key  = control_key(b);
    assign wr_idx   = IDX_W'(len_reg - 1'b1);

    always_comb
    begin
        mode_next   = mode_reg;
        len_next    = len_reg;
        tick_next   = tick_reg;
        seq_next    = seq_reg;
        res_vld     = 1'b0;
        status_next = 1'b0;
        key_next    = KEY_CHAR;
        char_next   = BYTE_ZERO;
        match_len   = '0;
        cand        = '0;
        seq_key     = KEY_NONE;

        if (take)
        begin
            unique case (stage.item.kind)
                KIND_ERR:
                begin
                    mode_next   = MODE_IDLE;
                    len_next    = '0;
                    tick_next   = '0;
                    res_vld     = 1'b1;
                    status_next = 1'b1;
                end
                KIND_TICK:
                begin
                    if (mode_reg != MODE_IDLE)
                    begin
                        tick_next = tick_inc;
                        if (tick_inc >= timeout_reg)
                        begin
                            tick_next = '0;
                            len_next  = '0;
                            mode_next = MODE_IDLE;
                            if (mode_reg == MODE_ESC)
                            begin
                                res_vld  = 1'b1;
                                key_next = KEY_ESC;
                            end
                        end
                    end
                end
                KIND_BYTE:
                begin
                    tick_next = '0;
                    unique case (mode_reg)
                        MODE_IDLE:
                        begin
                            if (b >= BYTE_SPACE && b <= BYTE_TILDE)
                            begin
                                res_vld   = 1'b1;
                                char_next = b;
                            end
                            else if (b == BYTE_ESC)
                            begin
                                mode_next = MODE_ESC;
                                len_next  = LEN_W'(1);
                            end
                            else if (ctl_key != KEY_NONE)
                            begin
                                res_vld   = 1'b1;
                                key_next  = ctl_key;
                                char_next = BYTE_SPACE;
                            end
                        end
                        MODE_ESC:
                        begin
                            if (b != BYTE_ESC)
                            begin
                                if (b != BYTE_CSI && b != BYTE_SS3)
                                begin
                                    mode_next = MODE_IDLE;
                                    len_next  = '0;
                                    res_vld   = 1'b1;
                                    char_next = b;
                                end
                                else
                                begin
                                    seq_next[0] = b;
                                    len_next    = LEN_W'(2);
                                    mode_next   = MODE_SEQ;
                                end
                            end
                        end
                        MODE_SEQ:
                        begin
                            if (len_reg >= LEN_W'(1) && len_reg < LEN_W'(MAX_SEQ_LEN))
                            begin
                                seq_next[wr_idx] = b;
                                len_next  = len_reg + 1'b1;
                                match_len = len_reg;
                                for (int i = 0; i < SEQ_DEPTH; i++)
                                begin
                                    if (i < int'(match_len))
                                    begin
                                        cand = {cand[CAND_W-9:0], seq_next[i]};
                                    end
                                end
                                seq_key = seq_lookup(cand, match_len);
                                if (seq_key != KEY_NONE)
                                begin
                                    mode_next = MODE_IDLE;
                                    len_next  = '0;
                                    res_vld   = 1'b1;
                                    key_next  = seq_key;
                                    char_next = BYTE_SPACE;
                                end
                                else if (len_next >= LEN_W'(MAX_SEQ_LEN))
                                begin
                                    mode_next = MODE_IDLE;
                                    len_next  = '0;
                                end
                            end
                            else
                            begin
                                mode_next = MODE_IDLE;
                                len_next  = '0;
                            end
                        end
                        default:
                        begin
                            mode_next = MODE_IDLE;
                            len_next  = '0;
                        end
                    endcase
                end
                default:
                begin
                    res_vld = 1'b0;
                end
            endcase
        end

        if (take)
        begin
            out_vld_next = res_vld;
        end
        else if (out_ready)
        begin
            out_vld_next = 1'b0;
        end
        else
        begin
            out_vld_next = out_vld_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_IDLE;
            len_reg     <= '0;
            tick_reg    <= '0;
            timeout_reg <= TIMEOUT_RESET;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            mode_reg    <= mode_next;
            len_reg     <= len_next;
            tick_reg    <= tick_next;
            out_vld_reg <= out_vld_next;
            if (cfg_we)
            begin
                timeout_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        seq_reg <= seq_next;
        if (take && res_vld)
        begin
            status_reg <= status_next;
            key_reg    <= key_next;
            char_reg   <= char_next;
        end
    end

    assign out_valid  = out_vld_reg;
    assign status     = status_reg;
    assign key_code   = key_reg;
    assign char_value = char_reg;

    `ASSERT_CLK(a_idle_len_zero, (mode_reg != MODE_IDLE) || (len_reg == '0 && tick_reg == '0),
        "idle parser holds sequence length or tick count")
    `ASSERT_NEVER(a_seq_len_range, (mode_reg == MODE_SEQ) &&
        (len_reg < LEN_W'(2) || len_reg >= LEN_W'(MAX_SEQ_LEN)),
        "sequence length out of range in sequence mode")
    `ASSERT_CLK(a_err_report, (take && stage.item.kind == KIND_ERR) |=>
        (mode_reg == MODE_IDLE && out_vld_reg && status_reg),
        "link error not reported or parser not reset")

endmodule

/* hdl/terminal_key_sequence_decoder_top.sv */
// ----------------------------------------------------------------------------
// terminal_key_sequence_decoder_top
// Decodes terminal bytes, ticks and link errors into key codes.
// ----------------------------------------------------------------------------
// An accepted word waits in the input register, its result in the result register.
// Throughput: one input word per cycle while out_ready keeps up; each register
// holds one word, so both sides may stall independently.
// Reset: parser idle, sequence length zero, tick count zero, timeout 200 ticks.
// No clearing pass; words are taken from the first cycle after reset.
module terminal_key_sequence_decoder_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  kind,
    input  logic [7:0]  byte_value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        status,
    output logic [5:0]  key_code,
    output logic [7:0]  char_value,
    input  logic        cfg_we,
    input  logic [15:0] cfg_data
);
    import tksd_pkg::*;

    in_stage_t stage;
    logic      take;

    tksd_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .kind       (kind),
        .byte_value (byte_value),
        .take       (take),
        .stage      (stage)
    );

    tksd_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .stage      (stage),
        .take       (take),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .key_code   (key_code),
        .char_value (char_value)
    );

endmodule

/* tb/tksd_key_checker.sv */
// ----------------------------------------------------------------------------
// tksd_key_checker
// Watches the byte, key and timeout register ports of the terminal key
// sequence decoder. It decodes every accepted input word on its own and
// checks each key word that leaves the block against the oldest one expected.
// ----------------------------------------------------------------------------
module tksd_key_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [1:0]  kind,
    input  logic [7:0]  byte_value,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic        status,
    input  logic [5:0]  key_code,
    input  logic [7:0]  char_value,
    input  logic        cfg_we,
    input  logic [15:0] cfg_data,
    output int          mismatches,
    output int          pending,
    output int          keys_seen
);

    import tksd_pkg::*;

    typedef enum logic [5:0] {
        KEY_BACKSPACE = 6'd2, KEY_CR, KEY_RETURN, KEY_TAB, KEY_NUL,
        KEY_BEGIN_OF_LINE, KEY_ARROW_LEFT, KEY_CANCEL_TEXT, KEY_END_OF_LINE,
        KEY_ARROW_RIGHT, KEY_CLEAR_EOL, KEY_ARROW_DOWN, KEY_ARROW_UP,
        KEY_CLEAR_LINE, KEY_INSERT, KEY_DELETE, KEY_PAGE_UP, KEY_PAGE_DOWN,
        KEY_CTRL_LEFT, KEY_CTRL_RIGHT,
        KEY_F1, KEY_F2, KEY_F3, KEY_F4, KEY_F5, KEY_F6,
        KEY_F7, KEY_F8, KEY_F9, KEY_F10, KEY_F11, KEY_F12
    } term_key_t;

    typedef struct packed {
        logic       status;
        logic [5:0] code;
        logic [7:0] ch;
    } key_word_t;

    mode_t                   mode;
    logic [8*SEQ_DEPTH-1:0]  seq_text;
    int                      seq_len;
    logic [TICK_W-1:0]       idle_ticks;
    logic [TICK_W-1:0]       timeout_ticks;
    key_word_t               expected_keys [$];
    key_word_t               want;
    key_word_t               got;
    key_word_t               fresh;
    bit                      hit;

    function automatic logic [5:0] control_code(input logic [7:0] b);
        logic [5:0] k;
        case (b)
            8'h08, 8'h7F: k = KEY_BACKSPACE;
            8'h0D:        k = KEY_CR;
            8'h0A:        k = KEY_RETURN;
            8'h09:        k = KEY_TAB;
            8'h00:        k = KEY_NUL;
            8'h01:        k = KEY_BEGIN_OF_LINE;
            8'h02:        k = KEY_ARROW_LEFT;
            8'h03:        k = KEY_CANCEL_TEXT;
            8'h04, 8'h05: k = KEY_END_OF_LINE;
            8'h06:        k = KEY_ARROW_RIGHT;
            8'h0B:        k = KEY_CLEAR_EOL;
            8'h0E:        k = KEY_ARROW_DOWN;
            8'h10:        k = KEY_ARROW_UP;
            8'h15:        k = KEY_CLEAR_LINE;
            default:      k = KEY_NONE;
        endcase
        return k;
    endfunction

    // text holds the bytes after ESC, newest in the low byte; n is their count
    function automatic logic [5:0] sequence_key(input logic [8*SEQ_DEPTH-1:0] text,
                                                input int n);
        logic [5:0] k;
        k = KEY_NONE;
        case (n)
            2: case (text[15:0])
                "[A": k = KEY_ARROW_UP;
                "[B": k = KEY_ARROW_DOWN;
                "[C": k = KEY_ARROW_RIGHT;
                "[D": k = KEY_ARROW_LEFT;
                "[F": k = KEY_END_OF_LINE;
                "[H": k = KEY_BEGIN_OF_LINE;
                "OP": k = KEY_F1;
                "OQ": k = KEY_F2;
                "OR": k = KEY_F3;
                "OS": k = KEY_F4;
                default: ;
            endcase
            3: case (text[23:0])
                "[1~", "[7~": k = KEY_BEGIN_OF_LINE;
                "[2~":        k = KEY_INSERT;
                "[3~":        k = KEY_DELETE;
                "[4~", "[8~": k = KEY_END_OF_LINE;
                "[5~":        k = KEY_PAGE_UP;
                "[6~":        k = KEY_PAGE_DOWN;
                "[[A":        k = KEY_F1;
                "[[B":        k = KEY_F2;
                "[[C":        k = KEY_F3;
                "[[D":        k = KEY_F4;
                "[[E":        k = KEY_F5;
                default: ;
            endcase
            4: case (text[31:0])
                "[15~": k = KEY_F5;
                "[17~": k = KEY_F6;
                "[18~": k = KEY_F7;
                "[19~": k = KEY_F8;
                "[20~": k = KEY_F9;
                "[21~": k = KEY_F10;
                "[23~": k = KEY_F11;
                "[24~": k = KEY_F12;
                default: ;
            endcase
            5: case (text[39:0])
                "[1;5D": k = KEY_CTRL_LEFT;
                "[1;5C": k = KEY_CTRL_RIGHT;
                default: ;
            endcase
            default: ;
        endcase
        return k;
    endfunction

    task automatic decode_word(input logic [1:0] k, input logic [7:0] b,
                               output bit emit, output key_word_t w);
        logic [5:0] code;
        emit = 1'b0;
        w    = '0;
        case (k)
            KIND_ERR: begin
                mode       = MODE_IDLE;
                seq_len    = 0;
                idle_ticks = '0;
                emit       = 1'b1;
                w          = '{1'b1, KEY_CHAR, BYTE_ZERO};
            end
            KIND_TICK: begin
                if (mode != MODE_IDLE) begin
                    if (idle_ticks != '1)
                        idle_ticks = idle_ticks + 1'b1;
                    if (idle_ticks >= timeout_ticks) begin
                        idle_ticks = '0;
                        seq_len    = 0;
                        if (mode == MODE_ESC) begin
                            emit = 1'b1;
                            w    = '{1'b0, KEY_ESC, BYTE_ZERO};
                        end
                        mode = MODE_IDLE;
                    end
                end
            end
            KIND_BYTE: begin
                idle_ticks = '0;
                case (mode)
                    MODE_IDLE: begin
                        code = control_code(b);
                        if (b >= BYTE_SPACE && b <= BYTE_TILDE) begin
                            emit = 1'b1;
                            w    = '{1'b0, KEY_CHAR, b};
                        end else if (b == BYTE_ESC) begin
                            mode    = MODE_ESC;
                            seq_len = 1;
                        end else if (code != KEY_NONE) begin
                            emit = 1'b1;
                            w    = '{1'b0, code, BYTE_SPACE};
                        end
                    end
                    MODE_ESC: begin
                        if (b == BYTE_CSI || b == BYTE_SS3) begin
                            seq_text = {{(8*SEQ_DEPTH-8){1'b0}}, b};
                            seq_len  = 2;
                            mode     = MODE_SEQ;
                        end else if (b != BYTE_ESC) begin
                            mode    = MODE_IDLE;
                            seq_len = 0;
                            emit    = 1'b1;
                            w       = '{1'b0, KEY_CHAR, b};
                        end
                    end
                    default: begin
                        seq_text = {seq_text[8*SEQ_DEPTH-9:0], b};
                        seq_len  = seq_len + 1;
                        code     = sequence_key(seq_text, seq_len - 1);
                        if (code != KEY_NONE) begin
                            mode    = MODE_IDLE;
                            seq_len = 0;
                            emit    = 1'b1;
                            w       = '{1'b0, code, BYTE_SPACE};
                        end else if (seq_len >= MAX_SEQ_LEN) begin
                            mode    = MODE_IDLE;
                            seq_len = 0;
                        end
                    end
                endcase
            end
            default: ;
        endcase
    endtask

    task automatic check_field(input string name, input logic [7:0] exp_v,
                               input logic [7:0] act_v);
        if (act_v !== exp_v) begin
            mismatches = mismatches + 1;
            if (mismatches <= 10)
                $display("mismatch on %s: expected %0h, got %0h", name, exp_v, act_v);
        end
    endtask

    always @(posedge clk) begin
        if (!rst_n) begin
            mode          = MODE_IDLE;
            seq_text      = '0;
            seq_len       = 0;
            idle_ticks    = '0;
            timeout_ticks = TIMEOUT_RESET;
            expected_keys.delete();
        end else begin
            if (out_valid && out_ready) begin
                keys_seen = keys_seen + 1;
                got       = '{status, key_code, char_value};
                if (expected_keys.size() == 0) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("unexpected key word: status %0h key %0d char %0h",
                                 status, key_code, char_value);
                end else begin
                    want = expected_keys.pop_front();
                    check_field("status", 8'(want.status), 8'(got.status));
                    check_field("key_code", 8'(want.code), 8'(got.code));
                    check_field("char_value", want.ch, got.ch);
                end
            end
            if (cfg_we)
                timeout_ticks = cfg_data;
            if (in_valid && in_ready) begin
                decode_word(kind, byte_value, hit, fresh);
                if (hit)
                    expected_keys.push_back(fresh);
            end
        end
        pending <= expected_keys.size();
    end

endmodule

/* tb/tb_terminal_key_sequence_decoder_top.sv */
// ----------------------------------------------------------------------------
// tb_terminal_key_sequence_decoder_top
// Drives terminal bytes, timer ticks and link errors into the decoder under
// several timeout settings, with random stalls on both sides, and lets the
// key checker judge every key word that comes out.
// ----------------------------------------------------------------------------
module tb_terminal_key_sequence_decoder_top;

    import tksd_pkg::*;

    localparam logic [1:0] KIND_NONE   = 2'd3;
    localparam int         CYCLE_LIMIT = 1_000_000;

    logic        clk;
    logic        rst_n      = 1'b0;
    logic        in_valid   = 1'b0;
    logic        in_ready;
    logic [1:0]  kind       = KIND_BYTE;
    logic [7:0]  byte_value = 8'h00;
    logic        out_valid;
    logic        out_ready  = 1'b0;
    logic        status;
    logic [5:0]  key_code;
    logic [7:0]  char_value;
    logic        cfg_we     = 1'b0;
    logic [15:0] cfg_data   = 16'h0000;

    int mismatches;
    int pending;
    int keys_seen;
    int cycles = 0;
    int words_sent = 0;
    int settings_used = 1;
    bit calm = 1'b0;
    bit gaps_on = 1'b1;
    bit long_hold = 1'b0;

    string key_texts [33] = '{
        "[1~", "[2~", "[3~", "[4~", "[5~", "[6~", "[7~", "[8~", "[1;5D", "[1;5C",
        "[A", "[B", "[C", "[D", "[F", "[H", "[[A", "[[B", "[[C", "[[D", "[[E",
        "OP", "OQ", "OR", "OS", "[15~", "[17~", "[18~", "[19~", "[20~", "[21~",
        "[23~", "[24~"
    };
    logic [7:0] control_bytes [16] = '{
        8'h08, 8'h0D, 8'h0A, 8'h09, 8'h00, 8'h01, 8'h02, 8'h03,
        8'h04, 8'h05, 8'h06, 8'h0B, 8'h0E, 8'h10, 8'h15, 8'h7F
    };
    string seq_alphabet = "0123456789;~[ABCDEFHOPQRS";

    terminal_key_sequence_decoder_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .kind       (kind),
        .byte_value (byte_value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .key_code   (key_code),
        .char_value (char_value),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data)
    );

    tksd_key_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .kind       (kind),
        .byte_value (byte_value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .key_code   (key_code),
        .char_value (char_value),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .pending    (pending),
        .keys_seen  (keys_seen)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // key sink: random stall bursts, quiet stretches, one long hold on request
    initial begin
        @(posedge clk);
        forever begin
            if (long_hold) begin
                out_ready <= 1'b0;
                repeat (80) @(posedge clk);
                long_hold = 1'b0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end else if (!calm && $urandom_range(0, 49) == 0) begin
                out_ready <= 1'b1;
                repeat ($urandom_range(20, 60)) @(posedge clk);
            end else begin
                out_ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    task automatic send_word(input logic [1:0] k, input logic [7:0] b);
        in_valid   <= 1'b1;
        kind       <= k;
        byte_value <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        words_sent = words_sent + 1;
        if (!calm && gaps_on && $urandom_range(0, 7) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_word(KIND_BYTE, b);
    endtask

    task automatic send_ticks(input int n);
        repeat (n) send_word(KIND_TICK, 8'($urandom_range(0, 255)));
    endtask

    task automatic send_escape(input string s);
        send_byte(BYTE_ESC);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    function automatic logic [7:0] noisy_seq_byte();
        if ($urandom_range(0, 9) == 0)
            return 8'($urandom_range(0, 255));
        return seq_alphabet[$urandom_range(0, seq_alphabet.len() - 1)];
    endfunction

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_timeout(input logic [15:0] v);
        drain();
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we   <= 1'b0;
        settings_used = settings_used + 1;
    endtask

    task automatic random_traffic(input int count, input int tmo);
        int stop;
        stop = words_sent + count;
        while (words_sent < stop) begin
            gaps_on = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 11))
                0, 1: send_byte(8'($urandom_range(BYTE_SPACE, BYTE_TILDE)));
                2: send_byte(8'($urandom_range(0, 255)));
                3: send_byte(control_bytes[$urandom_range(0, 15)]);
                4, 5, 6: send_escape(key_texts[$urandom_range(0, 32)]);
                7: begin
                    send_byte(BYTE_ESC);
                    send_byte($urandom_range(0, 1) ? BYTE_CSI : BYTE_SS3);
                    repeat ($urandom_range(0, 6)) send_byte(noisy_seq_byte());
                end
                8: begin
                    repeat ($urandom_range(1, 3)) send_byte(BYTE_ESC);
                    send_byte(8'($urandom_range(0, 255)));
                end
                9: begin
                    send_byte(BYTE_ESC);
                    if ($urandom_range(0, 1)) begin
                        send_byte(BYTE_CSI);
                        send_byte(noisy_seq_byte());
                    end
                    send_ticks($urandom_range(0, (tmo < 40) ? tmo + 1 : 40));
                end
                10: begin
                    if ($urandom_range(0, 1)) begin
                        send_byte(BYTE_ESC);
                        send_byte(BYTE_CSI);
                    end
                    send_word(KIND_ERR, 8'($urandom_range(0, 255)));
                end
                default: send_word($urandom_range(0, 1) ? KIND_NONE : KIND_TICK,
                                   8'($urandom_range(0, 255)));
            endcase
        end
    endtask

    initial begin
        int tmo;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset timeout of 200 ticks
        send_byte(BYTE_SPACE);
        send_byte(BYTE_TILDE);
        send_byte(8'h1F);
        send_byte(8'h7F);
        send_byte(8'h80);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_word(KIND_TICK, 8'hFF);
        send_word(KIND_NONE, 8'hFF);
        send_word(KIND_ERR, 8'hA5);
        send_escape("\033\033x");
        send_escape("\001");
        send_escape("[1;5D");
        send_escape("OP");
        send_escape("[24~");
        send_escape("[99999");
        send_byte("A");
        send_escape("[");
        send_word(KIND_ERR, 8'h5A);
        send_byte(BYTE_ESC);
        send_ticks(200);
        send_escape("[1");
        send_ticks(200);
        send_byte("z");

        set_timeout(16'd1);
        send_byte(BYTE_ESC);
        send_ticks(1);
        send_escape("[");
        send_ticks(1);
        send_byte("q");
        random_traffic(100, 1);

        set_timeout(16'd0);
        send_byte(BYTE_ESC);
        send_ticks(1);
        random_traffic(80, 0);

        set_timeout(16'hFFFF);
        gaps_on = 1'b0;
        send_byte(BYTE_ESC);
        send_ticks(50);
        send_escape("[A");
        random_traffic(100, 65535);

        for (int phase = 0; phase < 3; phase++) begin
            tmo = $urandom_range(2, 12);
            set_timeout(16'(tmo));
            if (phase == 1) begin
                long_hold = 1'b1;
                repeat (40) send_byte(8'($urandom_range(BYTE_SPACE, BYTE_TILDE)));
            end
            random_traffic(200, tmo);
        end

        set_timeout(TIMEOUT_RESET);
        calm = 1'b1;
        random_traffic(200, TIMEOUT_RESET);

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("summary: %0d input words sent, %0d key words checked",
                 words_sent, keys_seen);
        $display("summary: %0d timeout settings including 0, 1 and 65535", settings_used);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
